### hdl/sssd_pkg.sv
// Shared types, constants and segment pattern tables for the serial
// seven-segment display driver. No dependencies.
package sssd_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned HALF_BITS = 16;

	typedef logic [3:0] digit_t;
	typedef logic [HALF_BITS-1:0] pattern_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic valid;
		logic data;
		logic last;
	} cell_t;

	// first and third positions: P C D E - - - - - - - - G F A B
	function automatic pattern_t outer_pattern(input digit_t d);
		pattern_t p;
		case (d)
			4'd0: p = 16'h7007;
			4'd1: p = 16'h4001;
			4'd2: p = 16'h300B;
			4'd3: p = 16'h600B;
			4'd4: p = 16'h400D;
			4'd5: p = 16'h600E;
			4'd6: p = 16'h700E;
			4'd7: p = 16'h4003;
			4'd8: p = 16'h700F;
			4'd9: p = 16'h600F;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

	// second position: - - - - P C D E G F A B - - - -
	function automatic pattern_t middle_pattern(input digit_t d);
		pattern_t p;
		case (d)
			4'd0: p = 16'h0770;
			4'd1: p = 16'h0410;
			4'd2: p = 16'h03B0;
			4'd3: p = 16'h06B0;
			4'd4: p = 16'h04D0;
			4'd5: p = 16'h06E0;
			4'd6: p = 16'h07E0;
			4'd7: p = 16'h0430;
			4'd8: p = 16'h07F0;
			4'd9: p = 16'h06F0;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

endpackage

### hdl/seven_segment_serial_display_driver.sv
// Top level of the serial seven-segment display driver: digit decode
// pipeline feeding a 33-cell shift chain. Depends on sssd_pkg,
// sssd_decode and sssd_cell.
//
// Usage: each value request (value_valid high, value_stall low at a rising
// edge) is turned into 33 bit requests on the seg channel: 32 serial data
// bits of the segment word, LSB first, with bit_index 0..31, then one
// latch request with latch_last high, data_bit and bit_index zero.
// Path: an accepted value passes the decode pipeline, then loads into the
// shift chain, whose first cell drives seg. Throughput: one result per cycle
// with no stall; the decode pipeline holds up to four further values, and the
// next word loads into the chain in the cycle its last result is taken.
// Rate is set by the shift chain, which delivers one result a cycle while seg_stall is low.
// Reset clears all valid flags; the block is then empty and ready.
// A stall on seg_stall freezes the chain; the decode pipeline fills and
// then raises value_stall.
module seven_segment_serial_display_driver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       value_valid,
	output logic       value_stall,
	input  logic [9:0] value,
	output logic       seg_valid,
	input  logic       seg_stall,
	output logic       data_bit,
	output logic [4:0] bit_index,
	output logic       latch_last
);
	import sssd_pkg::*;

	localparam int unsigned CELLS = WORD_BITS + 1;

	logic       word_valid;
	logic       shift;
	logic       load;
	word_t      word;
	cell_t      cells   [CELLS];
	cell_t      loads   [CELLS];
	cell_t      nexts   [CELLS];
	logic [4:0] index_q;

	sssd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.word_valid  (word_valid),
		.word_take   (load),
		.word        (word)
	);

	assign shift = !cells[0].valid || !seg_stall;
	assign load  = word_valid && !cells[1].valid && shift;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		if (k < WORD_BITS) begin : g_bit
			assign loads[k] = '{valid: 1'b1, data: word[k], last: 1'b0};
			assign nexts[k] = cells[k+1];
		end else begin : g_latch
			assign loads[k] = '{valid: 1'b1, data: 1'b0, last: 1'b1};
			assign nexts[k] = '0;
		end
		sssd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.load      (load),
			.load_cell (loads[k]),
			.next_cell (nexts[k]),
			.cur_cell  (cells[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (load) begin
			index_q <= '0;
		end else if (cells[0].valid && !seg_stall) begin
			index_q <= index_q + 5'd1;
		end
	end

	assign seg_valid  = cells[0].valid;
	assign data_bit   = cells[0].data;
	assign latch_last = cells[0].last;
	assign bit_index  = cells[0].last ? 5'd0 : index_q;

endmodule

### hdl/sssd_decode.sv
// Four-stage stalling pipeline: splits a 10-bit value into decimal digits
// by reciprocal multiplication and builds the 32-bit segment word.
// Depends on sssd_pkg.
module sssd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 value_valid,
	output logic                 value_stall,
	input  logic [9:0]           value,
	output logic                 word_valid,
	input  logic                 word_take,
	output sssd_pkg::word_t      word
);
	import sssd_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic [9:0]  value_s1, value_s2;
	logic [3:0]  hraw_s2;
	logic [15:0] hprod;
	logic [9:0]  hscaled;
	logic [9:0]  rem_full;
	digit_t      hund_s3, hund_s4;
	logic [6:0]  rem_s3, rem_s4;
	logic [13:0] tprod;
	digit_t      tens_s4;
	logic [6:0]  ones_full;
	digit_t      ones;

	assign rdy_s4 = !v_s4 || word_take;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign value_stall = !rdy_s1;

	assign hprod    = {6'd0, value_s1} * 16'd41;
	assign hscaled  = {6'd0, hraw_s2} * 10'd100;
	assign rem_full = value_s2 - hscaled;
	assign tprod    = {7'd0, rem_s3} * 14'd103;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= value_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && value_valid) begin
			value_s1 <= value;
		end
		if (rdy_s2 && v_s1) begin
			value_s2 <= value_s1;
			hraw_s2  <= hprod[15:12];
		end
		if (rdy_s3 && v_s2) begin
			hund_s3 <= (hraw_s2 >= 4'd10) ? hraw_s2 - 4'd10 : hraw_s2;
			rem_s3  <= rem_full[6:0];
		end
		if (rdy_s4 && v_s3) begin
			hund_s4 <= hund_s3;
			rem_s4  <= rem_s3;
			tens_s4 <= tprod[13:10];
		end
	end

	assign ones_full  = rem_s4 - {3'd0, tens_s4} * 7'd10;
	assign ones       = ones_full[3:0];
	assign word_valid = v_s4;
	assign word       = {outer_pattern(hund_s4), middle_pattern(tens_s4) | outer_pattern(ones)};

endmodule

### hdl/sssd_cell.sv
// One cell of the output shift chain: holds one pending result and takes
// its neighbour's on each shift. Depends on sssd_pkg.
module sssd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            load,
	input  sssd_pkg::cell_t load_cell,
	input  sssd_pkg::cell_t next_cell,
	output sssd_pkg::cell_t cur_cell
);
	import sssd_pkg::*;

	cell_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (load) begin
			cell_q <= load_cell;
		end else if (shift) begin
			cell_q <= next_cell;
		end
	end

	assign cur_cell = cell_q;

endmodule

### tb/sv/tb_seven_segment_serial_display_driver.sv
// Testbench for the serial seven-segment display driver: sends values, predicts the
// 32 serial segment bits and the latch request for each, and checks every seg request.
// Depends on sssd_pkg and the seven_segment_serial_display_driver RTL.
module tb_seven_segment_serial_display_driver;
	import sssd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic       data_bit;
		logic [4:0] bit_index;
		logic       latch_last;
	} seg_request_t;

	// P C D E - - - - - - - - G F A B, outer display positions
	localparam pattern_t OUTER_GLYPH [10] = '{
		16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
		16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
	};
	// - - - - P C D E G F A B - - - -, middle display position
	localparam pattern_t MIDDLE_GLYPH [10] = '{
		16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
		16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       value_valid = 1'b0;
	logic       value_stall;
	logic [9:0] value = '0;
	logic       seg_valid;
	logic       seg_stall = 1'b0;
	logic       data_bit;
	logic [4:0] bit_index;
	logic       latch_last;

	seg_request_t pending_segments [$];
	int mismatches = 0;
	int cycle_count = 0;
	int sink_stall_pct = 0;
	int source_gap_pct = 0;
	int stall_left = 0;

	seven_segment_serial_display_driver uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.seg_valid   (seg_valid),
		.seg_stall   (seg_stall),
		.data_bit    (data_bit),
		.bit_index   (bit_index),
		.latch_last  (latch_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic word_t segment_word(input logic [9:0] v);
		int unsigned n;
		word_t w;
		n = v;
		w = {OUTER_GLYPH[(n / 100) % 10], 16'h0000};
		w |= {16'h0000, MIDDLE_GLYPH[(n / 10) % 10]};
		w |= {16'h0000, OUTER_GLYPH[n % 10]};
		return w;
	endfunction

	task automatic queue_segments(input logic [9:0] v);
		word_t w;
		w = segment_word(v);
		for (int k = 0; k < WORD_BITS; k++)
			pending_segments.push_back('{w[k], 5'(k), 1'b0});
		pending_segments.push_back('{1'b0, 5'd0, 1'b1});
	endtask

	task automatic send_value(input logic [9:0] v);
		int gap;
		if ($urandom_range(99) < source_gap_pct) begin
			gap = $urandom_range(1, 10);
			value_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (value_stall);
		queue_segments(v);
	endtask

	task automatic wait_for_segments();
		value_valid <= 1'b0;
		while (pending_segments.size() != 0) @(posedge clk);
	endtask

	function automatic logic [9:0] pick_value();
		case ($urandom_range(9))
			0: return 10'($urandom_range(1000, 1023));
			1: return 10'($urandom_range(0, 9));
			2: return 10'(888 - 800 * $urandom_range(0, 1) - 80 * $urandom_range(0, 1));
			3: return $urandom_range(1) ? 10'd1023 : 10'd999;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic test_directed_values();
		logic [9:0] corner [20] = '{
			10'd0, 10'd1, 10'd9, 10'd10, 10'd99, 10'd100, 10'd888, 10'd999, 10'd1000,
			10'd1009, 10'd1023, 10'd512, 10'd123, 10'd456, 10'd789, 10'd901, 10'd234,
			10'd567, 10'd345, 10'd678
		};
		sink_stall_pct = 0;
		source_gap_pct = 0;
		foreach (corner[i]) send_value(corner[i]);
		wait_for_segments();
	endtask

	task automatic test_back_to_back();
		sink_stall_pct = 40;
		source_gap_pct = 0;
		repeat (100) send_value(pick_value());
		wait_for_segments();
	endtask

	task automatic test_random_idling();
		for (int chunk = 0; chunk < 10; chunk++) begin
			sink_stall_pct = (chunk % 3 == 2) ? 0 : 20;
			source_gap_pct = (chunk % 3 == 1) ? 0 : 25;
			repeat (20) send_value(pick_value());
			if ($urandom_range(1)) wait_for_segments();
		end
		wait_for_segments();
	endtask

	task automatic test_no_idling();
		sink_stall_pct = 0;
		source_gap_pct = 0;
		repeat (140) send_value(pick_value());
		wait_for_segments();
	endtask

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (arst_n && $urandom_range(99) < sink_stall_pct)
			stall_left = $urandom_range(1, 10);
		seg_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		seg_request_t got;
		seg_request_t want;
		if (arst_n && seg_valid && !seg_stall) begin
			got = '{data_bit, bit_index, latch_last};
			if (pending_segments.size() == 0) begin
				$display("%0t: unexpected request, expected none, got %p", $time, got);
				mismatches++;
			end else begin
				want = pending_segments.pop_front();
				if (got.data_bit !== want.data_bit) begin
					$display("%0t: data_bit expected %0b got %0b", $time,
						want.data_bit, got.data_bit);
					mismatches++;
				end
				if (got.bit_index !== want.bit_index) begin
					$display("%0t: bit_index expected %0d got %0d", $time,
						want.bit_index, got.bit_index);
					mismatches++;
				end
				if (got.latch_last !== want.latch_last) begin
					$display("%0t: latch_last expected %0b got %0b", $time,
						want.latch_last, got.latch_last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_seven_segment_serial_display_driver NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_values();
		test_back_to_back();
		test_random_idling();
		test_no_idling();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_segments.size() == 0)
			$display("tb_seven_segment_serial_display_driver OK");
		else
			$display("tb_seven_segment_serial_display_driver NOT OK");
		$finish;
	end

endmodule
